// ===== hdl/bpfa_pkg.sv =====
package bpfa_pkg;

  localparam int unsigned COUNT_W   = 14;
  localparam int unsigned ADDR_W    = 25;
  localparam int unsigned CNT_W     = 29;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned WORD_LSB  = 5;
  localparam int unsigned POP_W     = 6;

  localparam logic [CNT_W-1:0] TOTAL_BYTES   = CNT_W'(512 * 1024 * 1024);
  localparam logic [CNT_W-1:0] FREE_AT_RESET = CNT_W'(256 * 1024 * 1024);
  localparam logic [CNT_W-1:0] USED_AT_RESET = CNT_W'(TOTAL_BYTES - FREE_AT_RESET);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_RUN = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [31:0]        start_address;
    logic [COUNT_W-1:0] page_count;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic              status;
    logic [CNT_W-1:0]  free_bytes;
    logic [CNT_W-1:0]  used_bytes;
  } out_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [POP_W-1:0]     pop;
    logic [WORD_LSB-1:0]  low;
    logic                 any;
  } word_res_t;

endpackage

// ===== hdl/bpfa_ram.sv =====
module bpfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/bpfa_word_unit.sv =====
module bpfa_word_unit #(
  parameter int unsigned BW = 6
) (
  input  logic [BW-1:0]                      base_i,
  input  logic [BW-1:0]                      lo_i,
  input  logic [BW-1:0]                      hi_i,
  input  logic [bpfa_pkg::WORD_BITS-1:0]     word_i,
  input  logic                               set_i,
  output bpfa_pkg::word_res_t                res_o
);

  always_comb begin
    logic [bpfa_pkg::WORD_BITS-1:0] mask;
    logic [bpfa_pkg::WORD_BITS-1:0] hit;
    logic [BW:0]                    pg;
    logic [bpfa_pkg::POP_W-1:0]     pop;
    logic [bpfa_pkg::WORD_LSB-1:0]  low;
    for (int j = 0; j < bpfa_pkg::WORD_BITS; j++) begin
      pg      = {1'b0, base_i} + (BW+1)'(j);
      mask[j] = (pg >= {1'b0, lo_i}) && (pg < {1'b0, hi_i});
    end
    hit = mask & word_i;
    pop = '0;
    for (int j = 0; j < bpfa_pkg::WORD_BITS; j++) begin
      pop = pop + bpfa_pkg::POP_W'(hit[j]);
    end
    low = '0;
    for (int j = bpfa_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        low = bpfa_pkg::WORD_LSB'(j);
      end
    end
    res_o.word = set_i ? (word_i | mask) : (word_i & ~hit);
    res_o.pop  = pop;
    res_o.low  = low;
    res_o.any  = |hit;
  end

endmodule

// ===== hdl/bitmap_page_frame_allocator.sv =====
// First-fit page allocator over a used-page bitmap kept in a 32-bit-wide RAM, one
// transaction at a time. After reset the block sweeps every word of the bitmap clear
// before it raises in_ready_o. An allocate scans from the search hint one RAM word at
// a time, examining page by page inside a mixed or partial word, then reads and
// rewrites each word of the run to mark it; a free reads and rewrites each word of its
// page range. The response state hands the result to the output register when the
// output is not stalled; the register holds it while the next transaction is taken
// in. Allocates of count zero or above NUM_PAGES and unaligned frees skip the bitmap
// and go straight to the response. PAGE_BYTES must be a power of two.
module bitmap_page_frame_allocator #(
  parameter int unsigned NUM_PAGES  = 8192,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bpfa_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bpfa_pkg::out_t out_data_o
);

  localparam int unsigned WORDS    = (NUM_PAGES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
  localparam int unsigned AW       = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int unsigned BW       = $clog2(NUM_PAGES + bpfa_pkg::WORD_BITS);
  localparam int unsigned PB_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned CW       = bpfa_pkg::COUNT_W;
  localparam int unsigned NW       = bpfa_pkg::CNT_W;
  localparam int unsigned WL       = bpfa_pkg::WORD_LSB;

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_SCAN_RD = 9'b000000100,
    ST_SCAN_EV = 9'b000001000,
    ST_BIT     = 9'b000010000,
    ST_UPD_RD  = 9'b000100000,
    ST_UPD_WR  = 9'b001000000,
    ST_RESP    = 9'b010000000,
    ST_SPARE   = 9'b100000000
  } state_e;

  function automatic logic [AW-1:0] widx_of(input logic [BW-1:0] page);
    return AW'(32'(page) >> WL);
  endfunction

  state_e                      state_q, state_d;
  logic                        op_q, op_d;
  logic [CW-1:0]               count_q, count_d;
  logic [BW-1:0]               p_q, p_d;
  logic [BW-1:0]               run_q, run_d;
  logic [BW-1:0]               rs_q, rs_d;
  logic [bpfa_pkg::WORD_BITS-1:0] word_q, word_d;
  logic [BW-1:0]               lo_q, lo_d;
  logic [BW-1:0]               hi_q, hi_d;
  logic [AW-1:0]               widx_q, widx_d;
  logic [AW-1:0]               last_q, last_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic [BW-1:0]               hint_q, hint_d;
  logic [NW-1:0]               free_q, free_d;
  logic [NW-1:0]               used_q, used_d;
  logic [bpfa_pkg::ADDR_W-1:0] blk_q, blk_d;
  logic                        status_q, status_d;
  logic                        out_valid_q;
  bpfa_pkg::out_t              out_q;
  logic                        load_out;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [AW-1:0]                  ram_raddr;
  logic [bpfa_pkg::WORD_BITS-1:0] ram_wdata;
  logic [bpfa_pkg::WORD_BITS-1:0] ram_rdata;

  bpfa_pkg::word_res_t wu_res;
  logic [BW-1:0]       wu_base;
  logic [BW-1:0]       low_page;
  logic [NW-1:0]       pop_bytes;
  logic [NW-1:0]       take_bytes;

  logic [31:0] f_first;
  logic [32:0] f_end;
  logic [32:0] f_lo;
  logic [32:0] f_hi;
  logic        f_aligned;

  logic          hit_run;
  logic          scan_fail;
  logic [BW-1:0] rs_sel;
  logic [BW-1:0] rs_cur;
  logic [BW-1:0] p_plus1;
  logic [BW-1:0] hi_sel;
  logic          fast;

  bpfa_ram #(
    .WIDTH(bpfa_pkg::WORD_BITS),
    .DEPTH(WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign wu_base = BW'(32'(widx_q) << WL);

  bpfa_word_unit #(
    .BW(BW)
  ) u_word (
    .base_i(wu_base),
    .lo_i  (lo_q),
    .hi_i  (hi_q),
    .word_i(ram_rdata),
    .set_i (op_q == bpfa_pkg::OP_ALLOC),
    .res_o (wu_res)
  );

  assign low_page   = wu_base + BW'(wu_res.low);
  assign pop_bytes  = NW'(32'(wu_res.pop) << PB_SHIFT);
  assign take_bytes = NW'(32'(count_q) << PB_SHIFT);

  assign f_first   = in_data_i.start_address >> PB_SHIFT;
  assign f_end     = 33'(f_first) + 33'(in_data_i.page_count);
  assign f_lo      = (f_first == 32'd0) ? 33'd1 : 33'(f_first);
  assign f_hi      = (f_end > 33'(NUM_PAGES)) ? 33'(NUM_PAGES) : f_end;
  assign f_aligned = in_data_i.start_address[PB_SHIFT-1:0] == '0;

  assign rs_cur  = (run_q == '0) ? p_q : rs_q;
  assign p_plus1 = p_q + BW'(1);
  assign fast    = (p_q[WL-1:0] == '0) && (32'(p_q) + bpfa_pkg::WORD_BITS <= NUM_PAGES);
  assign hi_sel  = rs_sel + BW'(count_q);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    count_d   = count_q;
    p_d       = p_q;
    run_d     = run_q;
    rs_d      = rs_q;
    word_d    = word_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    widx_d    = widx_q;
    last_d    = last_q;
    clr_d     = clr_q;
    hint_d    = hint_q;
    free_d    = free_q;
    used_d    = used_q;
    blk_d     = blk_q;
    status_d  = status_q;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = widx_q;
    ram_wdata = wu_res.word;
    ram_raddr = widx_q;
    hit_run   = 1'b0;
    scan_fail = 1'b0;
    rs_sel    = rs_cur;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_data_i.operation;
          count_d  = in_data_i.page_count;
          blk_d    = '0;
          status_d = bpfa_pkg::STATUS_OK;
          if (in_data_i.operation == bpfa_pkg::OP_ALLOC) begin
            if (in_data_i.page_count == '0 || 32'(in_data_i.page_count) > NUM_PAGES ||
                32'(hint_q) >= NUM_PAGES) begin
              status_d = bpfa_pkg::STATUS_NO_RUN;
              state_d  = ST_RESP;
            end else begin
              p_d     = hint_q;
              run_d   = '0;
              state_d = ST_SCAN_RD;
            end
          end else if (f_aligned && f_lo < f_hi) begin
            lo_d    = BW'(f_lo);
            hi_d    = BW'(f_hi);
            widx_d  = widx_of(BW'(f_lo));
            last_d  = widx_of(BW'(f_hi) - BW'(1));
            state_d = ST_UPD_RD;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN_RD: begin
        ram_raddr = widx_of(p_q);
        state_d   = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        if (fast && (ram_rdata == '0 || ram_rdata == '1)) begin
          if (ram_rdata == '0 &&
              32'(run_q) + bpfa_pkg::WORD_BITS >= 32'(count_q)) begin
            hit_run = 1'b1;
          end else begin
            if (ram_rdata == '0) begin
              run_d = run_q + BW'(bpfa_pkg::WORD_BITS);
              rs_d  = rs_cur;
            end else begin
              run_d = '0;
            end
            p_d = p_q + BW'(bpfa_pkg::WORD_BITS);
            if (32'(p_q) + bpfa_pkg::WORD_BITS >= NUM_PAGES) begin
              scan_fail = 1'b1;
            end else begin
              state_d = ST_SCAN_RD;
            end
          end
        end else begin
          word_d  = ram_rdata;
          state_d = ST_BIT;
        end
      end
      ST_BIT: begin
        if (!word_q[p_q[WL-1:0]] && 32'(run_q) + 32'd1 >= 32'(count_q)) begin
          hit_run = 1'b1;
        end else begin
          if (!word_q[p_q[WL-1:0]]) begin
            run_d = run_q + BW'(1);
            rs_d  = rs_cur;
          end else begin
            run_d = '0;
          end
          p_d = p_plus1;
          if (32'(p_plus1) >= NUM_PAGES) begin
            scan_fail = 1'b1;
          end else if (p_plus1[WL-1:0] == '0) begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_UPD_RD: begin
        state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        ram_we = 1'b1;
        if (op_q == bpfa_pkg::OP_FREE) begin
          free_d = free_q + pop_bytes;
          used_d = used_q - pop_bytes;
          if (wu_res.any && low_page < hint_q) begin
            hint_d = low_page;
          end
        end
        if (widx_q == last_q) begin
          state_d = ST_RESP;
        end else begin
          widx_d  = widx_q + AW'(1);
          state_d = ST_UPD_RD;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (hit_run) begin
      lo_d   = rs_sel;
      hi_d   = hi_sel;
      widx_d = widx_of(rs_sel);
      last_d = widx_of(hi_sel - BW'(1));
      free_d = free_q - take_bytes;
      used_d = used_q + take_bytes;
      if (count_q == CW'(1) && rs_sel == hint_q) begin
        hint_d = hint_q + BW'(1);
      end
      blk_d   = bpfa_pkg::ADDR_W'(32'(rs_sel) << PB_SHIFT);
      state_d = ST_UPD_RD;
    end
    if (scan_fail) begin
      status_d = bpfa_pkg::STATUS_NO_RUN;
      state_d  = ST_RESP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hint_q      <= '0;
      free_q      <= bpfa_pkg::FREE_AT_RESET;
      used_q      <= bpfa_pkg::USED_AT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hint_q  <= hint_d;
      free_q  <= free_d;
      used_q  <= used_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    count_q  <= count_d;
    p_q      <= p_d;
    run_q    <= run_d;
    rs_q     <= rs_d;
    word_q   <= word_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    widx_q   <= widx_d;
    last_q   <= last_d;
    blk_q    <= blk_d;
    status_q <= status_d;
    if (load_out) begin
      out_q.block_address <= blk_q;
      out_q.status        <= status_q;
      out_q.free_bytes    <= free_q;
      out_q.used_bytes    <= used_q;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
